### hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps
package cas_pkg;

    localparam int DEF_STAGE_COUNT = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int THRESH_W   = 16;
    localparam int DELAY_W    = 5;
    localparam int HOLD_W     = 16;
    localparam int CHANNEL_W  = 4;
    localparam int SEED_IDX_W = 4;
    localparam int INDEX_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNEL   = 3'd4;

    localparam logic signed [THRESH_W-1:0] RST_TRIGGER_HIGH  = 16'sd3277;
    localparam logic signed [THRESH_W-1:0] RST_TRIGGER_LOW   = 16'sd0;
    localparam logic [DELAY_W-1:0]         RST_CAPTURE_DELAY = 5'd10;
    localparam logic [HOLD_W-1:0]          RST_HOLD_TICKS    = 16'd48;
    localparam logic [CHANNEL_W-1:0]       RST_OUT_CHANNEL   = 4'd0;

    // Countdown: all ones means no capture pending.
    localparam int                 COUNT_W    = 6;
    localparam logic [COUNT_W-1:0] COUNT_IDLE = 6'd63;

    typedef struct packed {
        logic                  seed_write;
        logic                  load_seed;
        logic                  reset_shift;
        logic                  shift;
        logic [SEED_IDX_W-1:0] seed_idx;
    } cas_ctl_t;

endpackage

### hw/rtl/cas_front.sv
`timescale 1ns / 1ps
module cas_front #(
    parameter int SAMPLE_BITS = cas_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic                                   func,
    input  logic signed [SAMPLE_BITS-1:0]          clock_level,
    input  logic signed [SAMPLE_BITS-1:0]          reset_level,
    input  logic signed [SAMPLE_BITS-1:0]          cv_sample,
    input  logic                                   seed_connected,
    input  logic [cas_pkg::SEED_IDX_W-1:0]         seed_index,
    input  logic signed [SAMPLE_BITS-1:0]          seed_value,
    input  logic signed [cas_pkg::THRESH_W-1:0]    trigger_high,
    input  logic signed [cas_pkg::THRESH_W-1:0]    trigger_low,
    input  logic [cas_pkg::DELAY_W-1:0]            capture_delay,
    input  logic [cas_pkg::HOLD_W-1:0]             hold_ticks,
    output cas_pkg::cas_ctl_t                      ctl,
    output logic signed [SAMPLE_BITS-1:0]          data
);
    import cas_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic                      clk_hi_reg, clk_hi_next;
    logic                      rst_hi_reg, rst_hi_next;
    logic [HOLD_W-1:0]         hold_reg, hold_next;
    logic [COUNT_W-1:0]        count_reg, count_next;

    logic signed [CMP_W-1:0]   clk_ext, rst_ext, thr_hi, thr_lo;
    logic                      clk_edge, rst_edge, gate;
    logic [HOLD_W-1:0]         hold_base;
    logic [COUNT_W-1:0]        count_base;

    assign clk_ext = CMP_W'(clock_level);
    assign rst_ext = CMP_W'(reset_level);
    assign thr_hi  = CMP_W'(trigger_high);
    assign thr_lo  = CMP_W'(trigger_low);

    always_comb
    begin
        rst_hi_next = rst_hi_reg;
        rst_edge    = 1'b0;
        if (rst_hi_reg)
        begin
            if (rst_ext <= thr_lo)
                rst_hi_next = 1'b0;
        end
        else if (rst_ext >= thr_hi)
        begin
            rst_hi_next = 1'b1;
            rst_edge    = 1'b1;
        end

        clk_hi_next = clk_hi_reg;
        clk_edge    = 1'b0;
        if (clk_hi_reg)
        begin
            if (clk_ext <= thr_lo)
                clk_hi_next = 1'b0;
        end
        else if (clk_ext >= thr_hi)
        begin
            clk_hi_next = 1'b1;
            clk_edge    = 1'b1;
        end

        // reset edge extends the hold window, never shortens it
        hold_base = (rst_edge && (hold_ticks > hold_reg)) ? hold_ticks : hold_reg;
        gate      = (hold_base != '0);
        hold_next = gate ? hold_base - HOLD_W'(1) : hold_base;

        count_base = (clk_edge && !gate) ? COUNT_W'(capture_delay) : count_reg;
        count_next = (count_base != COUNT_IDLE) ? count_base - COUNT_W'(1) : count_base;

        ctl.seed_write  = func;
        ctl.load_seed   = rst_edge && seed_connected;
        ctl.reset_shift = rst_edge && !seed_connected;
        ctl.shift       = (count_base == '0);
        ctl.seed_idx    = seed_index;
        data            = func ? seed_value : cv_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hi_reg <= 1'b1;
            rst_hi_reg <= 1'b1;
            hold_reg   <= '0;
            count_reg  <= '0;
        end
        else if (accept && !func)
        begin
            clk_hi_reg <= clk_hi_next;
            rst_hi_reg <= rst_hi_next;
            hold_reg   <= hold_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/cas_queue.sv
`timescale 1ns / 1ps
module cas_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cas_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             not_empty,
    output logic             full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    fill_reg;

    assign dout      = mem_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + CW'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - CW'(1);
        end
    end

endmodule

### hw/rtl/cas_back.sv
`timescale 1ns / 1ps
module cas_back #(
    parameter int STAGE_COUNT = cas_pkg::DEF_STAGE_COUNT,
    parameter int SAMPLE_BITS = cas_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  cas_pkg::cas_ctl_t               q_ctl,
    input  logic signed [SAMPLE_BITS-1:0]   q_data,
    output logic                            q_pop,
    input  logic [cas_pkg::CHANNEL_W-1:0]   out_channel,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [cas_pkg::INDEX_W-1:0]     stage_index,
    output logic signed [SAMPLE_BITS-1:0]   stage_value,
    output logic signed [SAMPLE_BITS-1:0]   selected_value,
    output logic                            last
);
    import cas_pkg::*;

    localparam int IW  = $clog2(STAGE_COUNT);
    localparam int CHW = (IW > CHANNEL_W) ? IW : CHANNEL_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    logic [IW-1:0]                 cnt_reg, cnt_next;
    logic signed [SAMPLE_BITS-1:0] stages_reg [STAGE_COUNT];
    logic signed [SAMPLE_BITS-1:0] stages_next [STAGE_COUNT];
    logic signed [SAMPLE_BITS-1:0] seed_reg [STAGE_COUNT];
    logic signed [SAMPLE_BITS-1:0] sel_reg, sel_next;

    logic signed [SAMPLE_BITS-1:0] rot [STAGE_COUNT];
    logic signed [SAMPLE_BITS-1:0] base [STAGE_COUNT];
    logic signed [SAMPLE_BITS-1:0] s1 [STAGE_COUNT];
    logic signed [SAMPLE_BITS-1:0] s2 [STAGE_COUNT];
    logic [CHW-1:0]                ch_eff;
    logic                          xfer, is_last, tick_pop, seed_pop;

    assign xfer     = (state_reg == ST_EMIT) && !out_stall;
    assign is_last  = (cnt_reg == IW'(STAGE_COUNT - 1));
    assign q_pop    = q_valid && ((state_reg == ST_IDLE) || (xfer && is_last));
    assign tick_pop = q_pop && !q_ctl.seed_write;
    assign seed_pop = q_pop && q_ctl.seed_write;

    assign ch_eff = (CHW'(out_channel) > CHW'(STAGE_COUNT - 1)) ?
                    CHW'(STAGE_COUNT - 1) : CHW'(out_channel);

    // Emission rotates stage k+1 into stage k; a full pass restores the order.
    always_comb
    begin
        for (int k = 0; k < STAGE_COUNT - 1; k++)
            rot[k] = stages_reg[k + 1];
        rot[STAGE_COUNT - 1] = stages_reg[0];

        for (int k = 0; k < STAGE_COUNT; k++)
            base[k] = xfer ? rot[k] : stages_reg[k];

        for (int k = 0; k < STAGE_COUNT; k++)
        begin
            if (q_ctl.load_seed)
                s1[k] = seed_reg[k];
            else if (q_ctl.reset_shift)
                s1[k] = (k == 0) ? q_data : '0;
            else
                s1[k] = base[k];
        end

        for (int k = 0; k < STAGE_COUNT; k++)
        begin
            if (q_ctl.shift)
                s2[k] = (k == 0) ? q_data : s1[(k == 0) ? 0 : k - 1];
            else
                s2[k] = s1[k];
        end

        sel_next = sel_reg;
        for (int k = 0; k < STAGE_COUNT; k++)
        begin
            stages_next[k] = tick_pop ? s2[k] : base[k];
            if (tick_pop && (ch_eff == CHW'(k)))
                sel_next = s2[k];
        end

        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (xfer)
        begin
            cnt_next = cnt_reg + IW'(1);
            if (is_last)
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        end
        if (tick_pop)
        begin
            state_next = ST_EMIT;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            for (int k = 0; k < STAGE_COUNT; k++)
            begin
                stages_reg[k] <= '0;
                seed_reg[k]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            for (int k = 0; k < STAGE_COUNT; k++)
            begin
                stages_reg[k] <= stages_next[k];
                // drop seed writes beyond the last stage
                if (seed_pop && (32'(q_ctl.seed_idx) == k))
                    seed_reg[k] <= q_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    assign out_valid      = (state_reg == ST_EMIT);
    assign stage_index    = INDEX_W'(cnt_reg);
    assign stage_value    = stages_reg[0];
    assign selected_value = sel_reg;
    assign last           = is_last;

endmodule

### hw/rtl/clocked_analog_shift_register.sv
`timescale 1ns / 1ps
// Clocked analog shift register: STAGE_COUNT signed samples advanced by
// sample ticks (func 0) that carry clock, reset and CV levels; seed writes
// (func 1) fill the seed store and return nothing. The front end takes one
// item per cycle while in_stall is low, runs both Schmitt triggers, the hold
// window and the capture countdown, and queues a command (two entries deep);
// in_stall rises only while that queue is full. The back end applies one
// command per cycle while it is not streaming and then streams one result
// per cycle while out_stall is low, stage 0 first, last set on the final
// stage. A tick yields STAGE_COUNT results (16 by default), all through the
// single result port; back-to-back ticks follow with no gap, and a seed write
// yields no result. out_valid for the first result of a tick accepted into an
// empty block rises once the tick has passed the command queue register and
// the back-end state register. Configuration writes are always ready.
module clocked_analog_shift_register #(
    parameter int STAGE_COUNT = cas_pkg::DEF_STAGE_COUNT,
    parameter int SAMPLE_BITS = cas_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic signed [SAMPLE_BITS-1:0]      clock_level,
    input  logic signed [SAMPLE_BITS-1:0]      reset_level,
    input  logic signed [SAMPLE_BITS-1:0]      cv_sample,
    input  logic                               seed_connected,
    input  logic [cas_pkg::SEED_IDX_W-1:0]     seed_index,
    input  logic signed [SAMPLE_BITS-1:0]      seed_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cas_pkg::INDEX_W-1:0]        stage_index,
    output logic signed [SAMPLE_BITS-1:0]      stage_value,
    output logic signed [SAMPLE_BITS-1:0]      selected_value,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cas_pkg::*;

    localparam int QW = $bits(cas_ctl_t) + SAMPLE_BITS;

    logic signed [THRESH_W-1:0] trigger_high_reg;
    logic signed [THRESH_W-1:0] trigger_low_reg;
    logic [DELAY_W-1:0]         capture_delay_reg;
    logic [HOLD_W-1:0]          hold_ticks_reg;
    logic [CHANNEL_W-1:0]       out_channel_reg;

    logic                          in_xfer;
    cas_ctl_t                      f_ctl, q_ctl;
    logic signed [SAMPLE_BITS-1:0] f_data, q_data;
    logic [QW-1:0]                 q_dout;
    logic                          q_valid, q_full, q_pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_xfer   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_high_reg  <= RST_TRIGGER_HIGH;
            trigger_low_reg   <= RST_TRIGGER_LOW;
            capture_delay_reg <= RST_CAPTURE_DELAY;
            hold_ticks_reg    <= RST_HOLD_TICKS;
            out_channel_reg   <= RST_OUT_CHANNEL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TRIGGER_HIGH:  trigger_high_reg  <= THRESH_W'(cfg_data);
                REG_TRIGGER_LOW:   trigger_low_reg   <= THRESH_W'(cfg_data);
                REG_CAPTURE_DELAY: capture_delay_reg <= cfg_data[DELAY_W-1:0];
                REG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data[HOLD_W-1:0];
                REG_OUT_CHANNEL:   out_channel_reg   <= cfg_data[CHANNEL_W-1:0];
                default:           ;
            endcase
        end
    end

    cas_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_xfer),
        .func           (func),
        .clock_level    (clock_level),
        .reset_level    (reset_level),
        .cv_sample      (cv_sample),
        .seed_connected (seed_connected),
        .seed_index     (seed_index),
        .seed_value     (seed_value),
        .trigger_high   (trigger_high_reg),
        .trigger_low    (trigger_low_reg),
        .capture_delay  (capture_delay_reg),
        .hold_ticks     (hold_ticks_reg),
        .ctl            (f_ctl),
        .data           (f_data)
    );

    cas_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .din       ({f_ctl, f_data}),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_valid),
        .full      (q_full)
    );

    assign q_ctl  = q_dout[QW-1:SAMPLE_BITS];
    assign q_data = q_dout[SAMPLE_BITS-1:0];

    cas_back #(
        .STAGE_COUNT (STAGE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ctl          (q_ctl),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_channel    (out_channel_reg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .stage_index    (stage_index),
        .stage_value    (stage_value),
        .selected_value (selected_value),
        .last           (last)
    );

    // a finished tick is followed by nothing or by stage 0 of the next tick
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> (!out_valid || stage_index == '0))
        else $error("result stream did not restart at stage 0");

    // a tick never ends its result stream early
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("result stream dropped before the last stage");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

endmodule
